[hw/rtl/aav_pkg.sv]
// Shared constants and types for the ADC averaging voltmeter.
package aav_pkg;

  localparam int unsigned SAMPLE_W        = 10;
  localparam int unsigned TENTHS_W        = 6;
  localparam int unsigned BCD_W           = 8;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned SAMPLES_DEFAULT = 8;

  localparam int unsigned FULL_SCALE = 1023;
  localparam int unsigned TOP_TENTHS = 33;
  localparam int unsigned ROUND_BIAS = 511;

  // (mean*33 + 511) stays below 2^16
  localparam int unsigned SCALED_W    = 16;
  localparam int unsigned SCALE_SHIFT = 28;
  localparam int unsigned SCALE_MUL   = ((1 << SCALE_SHIFT) + FULL_SCALE - 1) / FULL_SCALE;
  localparam int unsigned SCALE_MUL_W = 19;

  // v/10 as (v*13)>>7, exact for v below 64
  localparam int unsigned TEN_MUL   = 13;
  localparam int unsigned TEN_SHIFT = 7;
  localparam int unsigned TEN_PROD_W = TENTHS_W + DIGIT_W + 1;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hw/rtl/aav_front.sv]
// Front end: accept samples, accumulate each block and hand off the block sum.
module aav_front
  import aav_pkg::*;
#(
  parameter int unsigned SAMPLES = SAMPLES_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      push,
  input  logic [SAMPLE_W-1:0]                       sample,
  input  q_stat_t                                   q_stat,
  output logic                                      full,
  output logic                                      blk_valid,
  output logic [$clog2(SAMPLES*FULL_SCALE+1)-1:0]   blk_sum
);

  localparam int unsigned SUM_W = $clog2(SAMPLES * FULL_SCALE + 1);
  localparam int unsigned CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  logic [SUM_W-1:0] sum_acc;
  logic [CNT_W-1:0] sample_count;
  logic [SUM_W-1:0] sum_next;
  logic             accept;
  logic             last;

  assign full     = q_stat.full;
  assign accept   = push && !q_stat.full;
  assign last     = (sample_count == CNT_W'(SAMPLES - 1));
  assign sum_next = sum_acc + SUM_W'(sample);

  assign blk_valid = accept && last;
  assign blk_sum   = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc      <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (last) begin
        sum_acc      <= '0;
        sample_count <= '0;
      end else begin
        sum_acc      <= sum_next;
        sample_count <= sample_count + CNT_W'(1);
      end
    end
  end

endmodule

[hw/rtl/aav_queue.sv]
// Two-entry queue of block sums between front and back end.
module aav_queue
  import aav_pkg::*;
#(
  parameter int unsigned WIDTH = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output q_stat_t          q_stat
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign rd_data      = mem[rd_ptr];
  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/aav_back.sv]
// Back end: mean, scaling to tenths, min/max tracking, BCD and output register.
module aav_back
  import aav_pkg::*;
#(
  parameter int unsigned SAMPLES = SAMPLES_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  q_stat_t                                   q_stat,
  input  logic [$clog2(SAMPLES*FULL_SCALE+1)-1:0]   q_data,
  output logic                                      q_rd,
  input  logic                                      pop,
  output logic                                      empty,
  output logic [TENTHS_W-1:0]                       tenths,
  output logic [BCD_W-1:0]                          bcd_value,
  output logic [TENTHS_W-1:0]                       min_tenths,
  output logic [TENTHS_W-1:0]                       max_tenths
);

  localparam int unsigned SUM_W      = $clog2(SAMPLES * FULL_SCALE + 1);
  localparam int unsigned MEAN_SHIFT = SUM_W + 5;
  localparam int unsigned MUL_W      = MEAN_SHIFT + 1;
  localparam int unsigned MPROD_W    = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] MEAN_MUL =
    MUL_W'(((64'd1 << MEAN_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
  localparam int unsigned SPROD_W = SCALED_W + SCALE_MUL_W;

  logic                  advance;
  logic                  out_valid;
  logic                  s1_valid;
  logic                  s2_valid;
  logic [SAMPLE_W-1:0]   s1_mean;
  logic [TENTHS_W-1:0]   s2_v;
  logic [TENTHS_W-1:0]   min_seen;
  logic [TENTHS_W-1:0]   max_seen;

  logic [MPROD_W-1:0]    mean_prod;
  logic [SCALED_W-1:0]   scaled;
  logic [SPROD_W-1:0]    scale_prod;
  logic [TEN_PROD_W-1:0] ten_prod;
  logic [DIGIT_W-1:0]    units;
  logic [DIGIT_W-1:0]    frac;
  logic [TENTHS_W-1:0]   min_next;
  logic [TENTHS_W-1:0]   max_next;

  assign advance = !out_valid || pop;
  assign q_rd    = advance && !q_stat.empty;
  assign empty   = !out_valid;

  assign mean_prod  = MPROD_W'(q_data) * MPROD_W'(MEAN_MUL);
  assign scaled     = (SCALED_W'(s1_mean) << 5) + SCALED_W'(s1_mean) + SCALED_W'(ROUND_BIAS);
  assign scale_prod = SPROD_W'(scaled) * SPROD_W'(SCALE_MUL);

  assign ten_prod = TEN_PROD_W'(s2_v) * TEN_PROD_W'(TEN_MUL);
  assign units    = ten_prod[TEN_SHIFT +: DIGIT_W];
  assign frac     = DIGIT_W'(s2_v - TENTHS_W'(units) * TENTHS_W'(10));
  assign min_next = (s2_v < min_seen) ? s2_v : min_seen;
  assign max_next = (s2_v > max_seen) ? s2_v : max_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      min_seen  <= TENTHS_W'(TOP_TENTHS);
      max_seen  <= '0;
    end else if (advance) begin
      s1_valid  <= q_rd;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
      if (s2_valid) begin
        min_seen <= min_next;
        max_seen <= max_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mean <= mean_prod[MEAN_SHIFT +: SAMPLE_W];
      s2_v    <= scale_prod[SCALE_SHIFT +: TENTHS_W];
      if (s2_valid) begin
        tenths     <= s2_v;
        bcd_value  <= {units, frac};
        min_tenths <= min_next;
        max_tenths <= max_next;
      end
    end
  end

endmodule

[hw/rtl/adc_average_voltmeter.sv]
// Top level of the ADC block-average voltmeter.
//
// Input channel: push/full with one 10-bit sample per word. Every SAMPLES
// accepted words form a block; the last word of a block hands the block sum
// to a two-entry queue, and the back end turns it into one result word.
// Result channel: empty/pop; the result shows tenths of a volt (0..33), its
// two-digit BCD form, and the running minimum and maximum after this block.
// Throughput: one sample per cycle while full is low. A block's sum passes
// through the queue, then the mean, scaled and output registers.
// The back end is a three-stage pipeline (reciprocal multiply for the mean,
// reciprocal multiply for the scaling, min/max/BCD into the output register)
// that advances whenever the output register is free or being popped.
// When the receiver stalls the pipeline holds, the queue fills, and full rises
// only once both queue entries hold block sums; samples are then held off.
// Reset clears the partial block, the queue and the pipeline, and sets the
// running minimum to 33 and the maximum to 0.
module adc_average_voltmeter
  import aav_pkg::*;
#(
  parameter int unsigned SAMPLES = SAMPLES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                empty,
  input  logic                pop,
  output logic [TENTHS_W-1:0] tenths,
  output logic [BCD_W-1:0]    bcd_value,
  output logic [TENTHS_W-1:0] min_tenths,
  output logic [TENTHS_W-1:0] max_tenths
);

  localparam int unsigned SUM_W = $clog2(SAMPLES * FULL_SCALE + 1);

  q_stat_t          q_stat;
  logic             blk_valid;
  logic [SUM_W-1:0] blk_sum;
  logic [SUM_W-1:0] q_data;
  logic             q_rd;

  aav_front #(
    .SAMPLES(SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .sample   (sample),
    .q_stat   (q_stat),
    .full     (full),
    .blk_valid(blk_valid),
    .blk_sum  (blk_sum)
  );

  aav_queue #(
    .WIDTH(SUM_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (blk_valid),
    .wr_data(blk_sum),
    .rd     (q_rd),
    .rd_data(q_data),
    .q_stat (q_stat)
  );

  aav_back #(
    .SAMPLES(SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_data    (q_data),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .tenths    (tenths),
    .bcd_value (bcd_value),
    .min_tenths(min_tenths),
    .max_tenths(max_tenths)
  );

endmodule
